>>> sv/dqce_pkg.sv
// shared types and constants for the deque with center extract
package dqce_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_EXTRACT    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    SH_HOLD,
    SH_RIGHT,
    SH_APPEND,
    SH_LEFT1,
    SH_LEFT2
  } shift_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    shift_t           kind;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] tap_a;
    logic [IDX_W-1:0] tap_b;
  } cmd_t;

endpackage

>>> sv/dqce_cell.sv
// one storage cell of the deque chain with neighbor shift and tap outputs
module dqce_cell (
  input  logic                      clk,
  input  logic [dqce_pkg::IDX_W-1:0] cell_idx,
  input  dqce_pkg::cmd_t            cmd,
  input  dqce_pkg::word_t           load_word,
  input  dqce_pkg::word_t           left_word,
  input  dqce_pkg::word_t           r1_word,
  input  dqce_pkg::word_t           r2_word,
  output dqce_pkg::word_t           word,
  output dqce_pkg::word_t           tap_a_word,
  output dqce_pkg::word_t           tap_b_word
);

  dqce_pkg::word_t word_r;
  dqce_pkg::word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (cmd.kind)
      dqce_pkg::SH_HOLD: begin
        word_nxt = word_r;
      end
      dqce_pkg::SH_RIGHT: begin
        word_nxt = (cell_idx == '0) ? load_word : left_word;
      end
      dqce_pkg::SH_APPEND: begin
        if (cell_idx == cmd.pos) word_nxt = load_word;
      end
      dqce_pkg::SH_LEFT1: begin
        if (cell_idx >= cmd.pos) word_nxt = r1_word;
      end
      dqce_pkg::SH_LEFT2: begin
        if (cell_idx >= cmd.pos) word_nxt = r2_word;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word       = word_r;
  assign tap_a_word = (cell_idx == cmd.tap_a) ? word_r : '0;
  assign tap_b_word = (cell_idx == cmd.tap_b) ? word_r : '0;

endmodule

>>> sv/deque_with_center_extract.sv
// top level of the bounded deque with center extract
//
//   channel  direction  ports
//   in       input      in_valid, in_stall, in_opcode, in_value
//   out      output     out_valid, out_stall, out_removed_count .. out_rejected
//
// each beat: the accept cycle updates the cell chain and captures removed
// words; the report state then reads the new back cell into the output
// register once that register is free, then the next beat is taken
// the output register holds a finished result while the next beat is accepted
// reset clears the count and the control state; cell contents are never read
// until written
module deque_with_center_extract (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            in_opcode,
  input  logic signed [dqce_pkg::DATA_WIDTH-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_removed_count,
  output logic signed [dqce_pkg::DATA_WIDTH-1:0] out_removed_first,
  output logic signed [dqce_pkg::DATA_WIDTH-1:0] out_removed_second,
  output logic signed [dqce_pkg::DATA_WIDTH-1:0] out_front_value,
  output logic signed [dqce_pkg::DATA_WIDTH-1:0] out_back_value,
  output logic [dqce_pkg::CNT_W-1:0]            out_occupancy,
  output logic                                  out_is_empty,
  output logic                                  out_rejected
);

  dqce_pkg::state_t state_r, state_nxt;
  logic [dqce_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [1:0]                 rcnt_r, rcnt_nxt;
  logic                       rej_r, rej_nxt;
  dqce_pkg::word_t            rem_a_r, rem_b_r;

  logic                       out_valid_r;
  logic [1:0]                 o_rcnt_r;
  dqce_pkg::word_t            o_first_r, o_second_r, o_front_r, o_back_r;
  logic [dqce_pkg::CNT_W-1:0] o_occ_r;
  logic                       o_empty_r, o_rej_r;

  dqce_pkg::cmd_t   cmd;
  dqce_pkg::cmd_t   op_cmd;
  dqce_pkg::word_t  words [dqce_pkg::DEPTH];
  dqce_pkg::word_t  taps_a [dqce_pkg::DEPTH];
  dqce_pkg::word_t  taps_b [dqce_pkg::DEPTH];
  dqce_pkg::word_t  bus_a, bus_b;

  logic accept;
  logic full, nonempty;
  logic [dqce_pkg::CNT_W-1:0] half, last;
  logic out_load;

  assign in_stall = (state_r != dqce_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == dqce_pkg::CNT_W'(dqce_pkg::DEPTH));
  assign nonempty = (count_r != '0);
  assign half     = count_r >> 1;
  assign last     = count_r - dqce_pkg::CNT_W'(1);
  assign out_load = (state_r == dqce_pkg::ST_REPORT) && (!out_valid_r || !out_stall);

  // decode the beat into a chain command
  always_comb begin
    op_cmd       = '0;
    op_cmd.kind  = dqce_pkg::SH_HOLD;
    count_nxt    = count_r;
    rcnt_nxt     = 2'd0;
    rej_nxt      = 1'b0;
    case (dqce_pkg::op_t'(in_opcode))
      dqce_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          rej_nxt = 1'b1;
        end else begin
          op_cmd.kind = dqce_pkg::SH_RIGHT;
          count_nxt   = count_r + dqce_pkg::CNT_W'(1);
        end
      end
      dqce_pkg::OP_PUSH_BACK: begin
        if (full) begin
          rej_nxt = 1'b1;
        end else begin
          op_cmd.kind = dqce_pkg::SH_APPEND;
          op_cmd.pos  = count_r[dqce_pkg::IDX_W-1:0];
          count_nxt   = count_r + dqce_pkg::CNT_W'(1);
        end
      end
      dqce_pkg::OP_POP_FRONT: begin
        if (nonempty) begin
          op_cmd.kind = dqce_pkg::SH_LEFT1;
          count_nxt   = last;
          rcnt_nxt    = 2'd1;
        end
      end
      dqce_pkg::OP_POP_BACK: begin
        if (nonempty) begin
          op_cmd.tap_a = last[dqce_pkg::IDX_W-1:0];
          count_nxt    = last;
          rcnt_nxt     = 2'd1;
        end
      end
      dqce_pkg::OP_EXTRACT: begin
        if (nonempty) begin
          if (count_r[0]) begin
            op_cmd.kind  = dqce_pkg::SH_LEFT1;
            op_cmd.pos   = half[dqce_pkg::IDX_W-1:0];
            op_cmd.tap_a = half[dqce_pkg::IDX_W-1:0];
            count_nxt    = last;
            rcnt_nxt     = 2'd1;
          end else begin
            op_cmd.kind  = dqce_pkg::SH_LEFT2;
            op_cmd.pos   = half[dqce_pkg::IDX_W-1:0] - dqce_pkg::IDX_W'(1);
            op_cmd.tap_a = half[dqce_pkg::IDX_W-1:0] - dqce_pkg::IDX_W'(1);
            op_cmd.tap_b = half[dqce_pkg::IDX_W-1:0];
            count_nxt    = count_r - dqce_pkg::CNT_W'(2);
            rcnt_nxt     = 2'd2;
          end
        end
      end
      default: begin
        op_cmd.kind = dqce_pkg::SH_HOLD;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = op_cmd;
    case (state_r)
      dqce_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dqce_pkg::ST_REPORT;
        end else begin
          cmd.kind = dqce_pkg::SH_HOLD;
        end
      end
      dqce_pkg::ST_REPORT: begin
        cmd       = '0;
        cmd.kind  = dqce_pkg::SH_HOLD;
        cmd.tap_a = last[dqce_pkg::IDX_W-1:0];
        if (out_load) state_nxt = dqce_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dqce_pkg::ST_IDLE;
        cmd.kind  = dqce_pkg::SH_HOLD;
      end
    endcase
  end

  // chain of cells
  for (genvar g = 0; g < dqce_pkg::DEPTH; g++) begin : g_cell
    dqce_pkg::word_t left_w, r1_w, r2_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = words[g-1];
    end
    if (g + 1 < dqce_pkg::DEPTH) begin : g_r1
      assign r1_w = words[g+1];
    end else begin : g_r1_end
      assign r1_w = '0;
    end
    if (g + 2 < dqce_pkg::DEPTH) begin : g_r2
      assign r2_w = words[g+2];
    end else begin : g_r2_end
      assign r2_w = '0;
    end
    dqce_cell u_cell (
      .clk        (clk),
      .cell_idx   (dqce_pkg::IDX_W'(g)),
      .cmd        (cmd),
      .load_word  (in_value),
      .left_word  (left_w),
      .r1_word    (r1_w),
      .r2_word    (r2_w),
      .word       (words[g]),
      .tap_a_word (taps_a[g]),
      .tap_b_word (taps_b[g])
    );
  end

  always_comb begin
    bus_a = '0;
    bus_b = '0;
    for (int i = 0; i < dqce_pkg::DEPTH; i++) begin
      bus_a = bus_a | taps_a[i];
      bus_b = bus_b | taps_b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqce_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured removal info and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      rcnt_r  <= rcnt_nxt;
      rej_r   <= rej_nxt;
      rem_a_r <= (rcnt_nxt != 2'd0) ? bus_a : '0;
      rem_b_r <= (rcnt_nxt == 2'd2) ? bus_b : '0;
    end
    if (out_load) begin
      o_rcnt_r   <= rcnt_r;
      o_first_r  <= rem_a_r;
      o_second_r <= rem_b_r;
      o_front_r  <= nonempty ? words[0] : '0;
      o_back_r   <= nonempty ? bus_a : '0;
      o_occ_r    <= count_r;
      o_empty_r  <= !nonempty;
      o_rej_r    <= rej_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_removed_count  = o_rcnt_r;
  assign out_removed_first  = o_first_r;
  assign out_removed_second = o_second_r;
  assign out_front_value    = o_front_r;
  assign out_back_value     = o_back_r;
  assign out_occupancy      = o_occ_r;
  assign out_is_empty       = o_empty_r;
  assign out_rejected       = o_rej_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dqce_pkg::CNT_W'(dqce_pkg::DEPTH))
    else $error("count above depth");

  a_valid_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == dqce_pkg::ST_REPORT))
    else $error("result without report cycle");

  a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |->
      (out_removed_count == 2'd0 && out_occupancy == dqce_pkg::CNT_W'(dqce_pkg::DEPTH)))
    else $error("reject while not full");

endmodule

>>> tb/dqce_checker.sv
// checker for the deque with center extract: predicts each result beat and compares it
`timescale 1ns / 100ps

module deque_checker
  import dqce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [2:0]            in_opcode,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            out_removed_count,
  input  logic [DATA_WIDTH-1:0] out_removed_first,
  input  logic [DATA_WIDTH-1:0] out_removed_second,
  input  logic [DATA_WIDTH-1:0] out_front_value,
  input  logic [DATA_WIDTH-1:0] out_back_value,
  input  logic [CNT_W-1:0]      out_occupancy,
  input  logic                  out_is_empty,
  input  logic                  out_rejected,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [1:0]       removed_count;
    word_t            removed_first;
    word_t            removed_second;
    word_t            front_value;
    word_t            back_value;
    logic [CNT_W-1:0] occupancy;
    logic             is_empty;
    logic             rejected;
  } step_view_t;

  word_t       cells [DEPTH];
  int unsigned fill;
  step_view_t  expected_views [$];

  // remove one cell and close the gap behind it
  function automatic word_t take_cell(input int unsigned pos);
    word_t w;
    w = cells[pos];
    for (int unsigned i = pos; i + 1 < fill; i++) cells[i] = cells[i + 1];
    fill--;
    return w;
  endfunction

  function automatic step_view_t step_deque(input logic [2:0] op, input word_t v);
    step_view_t r;
    int unsigned left;
    r = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          for (int unsigned i = fill; i > 0; i--) cells[i] = cells[i - 1];
          cells[0] = v;
          fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          cells[fill] = v;
          fill++;
        end
      end
      OP_POP_FRONT: begin
        if (fill > 0) begin
          r.removed_first = take_cell(0);
          r.removed_count = 2'd1;
        end
      end
      OP_POP_BACK: begin
        if (fill > 0) begin
          r.removed_first = take_cell(fill - 1);
          r.removed_count = 2'd1;
        end
      end
      OP_EXTRACT: begin
        if (fill > 0) begin
          if (fill % 2 == 1) begin
            r.removed_first = take_cell(fill / 2);
            r.removed_count = 2'd1;
          end else begin
            left             = fill / 2 - 1;
            r.removed_first  = take_cell(left);
            r.removed_second = take_cell(left);
            r.removed_count  = 2'd2;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(fill);
    r.is_empty  = (fill == 0);
    if (fill > 0) begin
      r.front_value = cells[0];
      r.back_value  = cells[fill - 1];
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                             input logic [DATA_WIDTH-1:0] got);
    if (got !== want) flag($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // sampled mid-cycle: the values here are the ones seen at the next rising edge
  always @(negedge clk) begin
    step_view_t want;
    if (!rst_n) begin
      fail_count  = 0;
      outstanding = 0;
      fill        = 0;
      expected_views.delete();
    end else begin
      if (in_valid && !in_stall) expected_views.push_back(step_deque(in_opcode, in_value));
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          flag("result beat with no expectation outstanding");
        end else begin
          want = expected_views.pop_front();
          check_field("removed_count", DATA_WIDTH'(want.removed_count),
                      DATA_WIDTH'(out_removed_count));
          check_field("removed_first", want.removed_first, out_removed_first);
          check_field("removed_second", want.removed_second, out_removed_second);
          check_field("front_value", want.front_value, out_front_value);
          check_field("back_value", want.back_value, out_back_value);
          check_field("occupancy", DATA_WIDTH'(want.occupancy), DATA_WIDTH'(out_occupancy));
          check_field("is_empty", DATA_WIDTH'(want.is_empty), DATA_WIDTH'(out_is_empty));
          check_field("rejected", DATA_WIDTH'(want.rejected), DATA_WIDTH'(out_rejected));
        end
      end
      outstanding = expected_views.size();
    end
  end

endmodule

>>> tb/testbench.sv
// top of the deque with center extract testbench: stimulus, stall patterns and verdict
`timescale 1ns / 100ps

module testbench;
  import dqce_pkg::*;

  localparam int    RANDOM_ITEMS = 600;
  localparam int    HOLD_CYCLES  = 200;
  localparam word_t WORD_MIN     = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t WORD_MAX     = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_opcode;
  word_t            in_value;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_removed_count;
  word_t            out_removed_first;
  word_t            out_removed_second;
  word_t            out_front_value;
  word_t            out_back_value;
  logic [CNT_W-1:0] out_occupancy;
  logic             out_is_empty;
  logic             out_rejected;

  int   fail_count;
  int   outstanding;
  int   burst_left;
  logic hold_req;
  logic hold_done;

  deque_with_center_extract i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_removed_count  (out_removed_count),
    .out_removed_first  (out_removed_first),
    .out_removed_second (out_removed_second),
    .out_front_value    (out_front_value),
    .out_back_value     (out_back_value),
    .out_occupancy      (out_occupancy),
    .out_is_empty       (out_is_empty),
    .out_rejected       (out_rejected)
  );

  deque_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_removed_count  (out_removed_count),
    .out_removed_first  (out_removed_first),
    .out_removed_second (out_removed_second),
    .out_front_value    (out_front_value),
    .out_back_value     (out_back_value),
    .out_occupancy      (out_occupancy),
    .out_is_empty       (out_is_empty),
    .out_rejected       (out_rejected),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("deque_with_center_extract verification failed");
    $finish;
  end

  // hold the beat until taken, then close the burst with a gap when it runs out
  task automatic send(input logic [2:0] op, input word_t v);
    logic taken;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // tilt 0 leans to pushes, 1 to removals, 2 is balanced
  function automatic logic [2:0] pick_op(input int tilt);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    push_pct = (tilt == 0) ? 72 : (tilt == 1) ? 25 : 48;
    if (r < 3) return OP_EXTRACT + 3'($urandom_range(1, 3));
    if (r < 3 + push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    case ($urandom_range(0, 2))
      0:       return OP_POP_FRONT;
      1:       return OP_POP_BACK;
      default: return OP_EXTRACT;
    endcase
  endfunction

  // receiver: segments of free flow, random stalls, a mostly stalled pattern and one long hold
  initial begin
    int phase_len;
    int stall_mode;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      stall_mode = $urandom_range(0, 2);
      phase_len  = $urandom_range(4, 40);
      for (int k = 0; k < phase_len; k++) begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 40);
          default: out_stall <= (k % 4 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int tilt;
    hold_req   = 1'b0;
    burst_left = $urandom_range(1, 24);
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_opcode <= OP_PUSH_FRONT;
    in_value  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // removals and unknown codes on an empty queue
    send(OP_POP_FRONT, WORD_MAX);
    send(OP_POP_BACK, WORD_MIN);
    send(OP_EXTRACT, '1);
    send(OP_EXTRACT + 3'd1, WORD_MAX);
    send(OP_EXTRACT + 3'd3, WORD_MIN);
    // single element taken as the center
    send(OP_PUSH_FRONT, WORD_MIN);
    send(OP_EXTRACT, '0);
    // fill to the top, push into a full queue from both ends, then remove from it
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       send(OP_PUSH_FRONT, WORD_MIN);
        1:       send(OP_PUSH_BACK, WORD_MAX);
        2:       send(OP_PUSH_FRONT, '1);
        default: send(OP_PUSH_BACK, word_t'($urandom));
      endcase
    end
    send(OP_PUSH_FRONT, '0);
    send(OP_PUSH_BACK, '1);
    send(OP_EXTRACT, '0);
    send(OP_POP_BACK, '0);
    send(OP_EXTRACT, '0);

    tilt = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) tilt = $urandom_range(0, 2);
      if (n == RANDOM_ITEMS / 2) hold_req = 1'b1;
      send(pick_op(tilt), pick_word());
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("deque_with_center_extract verification clean");
    end else begin
      $display("deque_with_center_extract verification failed");
    end
    $finish;
  end

endmodule
